// ===== rtl/ppp_pkg.sv =====
// Shared types and constants for the perspective point projection unit.
// Used by ppp_basis, perspective_point_projection_unit and ppp_checker; no dependencies.
package ppp_pkg;

	// Default number of fraction bits of the point and image coordinates.
	localparam int COORD_FRAC_BITS_DEF = 4;

	// Configuration register indexes.
	localparam logic [2:0] REG_CAM_POS_X    = 3'd0;
	localparam logic [2:0] REG_CAM_POS_Y    = 3'd1;
	localparam logic [2:0] REG_CAM_POS_Z    = 3'd2;
	localparam logic [2:0] REG_CAM_FORWARD  = 3'd3;
	localparam logic [2:0] REG_CAM_UP       = 3'd4;
	localparam logic [2:0] REG_FOCAL_LENGTH = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [19:0] CAM_POS_X_RST    = 20'sd0;
	localparam logic [19:0] CAM_POS_Y_RST    = 20'sd0;
	localparam logic [19:0] CAM_POS_Z_RST    = 20'hFE0C0;
	localparam logic [47:0] CAM_FORWARD_RST  = 48'h4000_0000_0000;
	localparam logic [47:0] CAM_UP_RST       = 48'h0000_4000_0000;
	localparam logic [15:0] FOCAL_LENGTH_RST = 16'd500;

	// One in Q2.14.
	localparam logic signed [15:0] Q14_ONE = 16'sd16384;

	// Output coordinate limits.
	localparam logic [19:0] IMG_MAX = 20'h7FFFF;
	localparam logic [19:0] IMG_MIN = 20'h80000;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_CROSS,
		BS_SUMSQ,
		BS_SQRT,
		BS_LOAD,
		BS_DIV
	} bs_state_t;

	// Normalized camera basis, each component Q2.14 signed.
	typedef struct packed {
		logic [2:0][15:0] right;
		logic [2:0][15:0] upn;
	} basis_t;

endpackage

// ===== rtl/ppp_basis.sv =====
// Sequential unit that rebuilds the normalized camera basis after a write.
// Depends on ppp_pkg for the state enum and the basis struct.
module ppp_basis (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [47:0]          fwd,
	input  logic [47:0]          up,
	output ppp_pkg::basis_t      basis,
	output logic                 busy
);

	ppp_pkg::bs_state_t state_q, state_d;

	logic [1:0]          cnt_q;
	logic [4:0]          it_q;
	logic                vec_q;
	logic signed [18:0]  vec_q_arr [3];
	logic [35:0]         ss_q;
	logic [35:0]         sv_q;
	logic [36:0]         res_q;
	logic [36:0]         bit_q;
	logic [18:0]         n_q;
	logic [33:0]         rem_q;
	logic [14:0]         quo_q;
	logic signed [15:0]  right_q [3];
	logic signed [15:0]  upn_q [3];

	logic signed [15:0] fw [3];
	logic signed [15:0] uv [3];
	logic signed [15:0] op_a, op_b, op_c, op_d;
	logic signed [31:0] p1, p2;
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [18:0]        rnd;
	logic signed [18:0] cr;
	logic signed [37:0] sq;
	logic [36:0]        sqt;
	logic               sq_ge;
	logic [36:0]        res_nx;
	logic [33:0]        dsh;
	logic               dv_ge;
	logic [14:0]        qfin;
	logic signed [15:0] qval;
	logic [17:0]        ld_abs;
	logic               last_it;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fw[i] = $signed(fwd[16*i +: 16]);
			uv[i] = $signed(up[16*i +: 16]);
		end
	end

	// Cross product component selected by cnt_q, rounded to 14 fraction bits (Q5.14).
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = fw[1]; op_b = uv[2]; op_c = fw[2]; op_d = uv[1];
			end
			2'd1: begin
				op_a = fw[2]; op_b = uv[0]; op_c = fw[0]; op_d = uv[2];
			end
			default: begin
				op_a = fw[0]; op_b = uv[1]; op_c = fw[1]; op_d = uv[0];
			end
		endcase
		p1   = op_a * op_b;
		p2   = op_c * op_d;
		diff = 33'(p1) - 33'(p2);
		mag  = diff[32] ? 33'(-diff) : 33'(diff);
		rnd  = 19'((mag + 33'd8192) >> 14);
		cr   = diff[32] ? -$signed(rnd) : $signed(rnd);
	end

	always_comb begin
		sq     = vec_q_arr[cnt_q] * vec_q_arr[cnt_q];
		sqt    = res_q + bit_q;
		sq_ge  = {1'b0, sv_q} >= sqt;
		res_nx = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
		dsh    = {14'd0, n_q, 1'b0} << it_q;
		dv_ge  = rem_q >= dsh;
		qfin   = {quo_q[13:0], dv_ge};
		qval   = (n_q == 19'd0) ? 16'sd0 :
			(vec_q_arr[cnt_q][18] ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin}));
		ld_abs = vec_q_arr[cnt_q][18] ? 18'(-vec_q_arr[cnt_q]) : 18'(vec_q_arr[cnt_q]);
		last_it = (it_q == 5'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppp_pkg::BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppp_pkg::BS_IDLE:  state_d = ppp_pkg::BS_IDLE;
			ppp_pkg::BS_CROSS: if (cnt_q == 2'd2) state_d = ppp_pkg::BS_SUMSQ;
			ppp_pkg::BS_SUMSQ: if (cnt_q == 2'd2) state_d = ppp_pkg::BS_SQRT;
			ppp_pkg::BS_SQRT:  if (last_it) state_d = ppp_pkg::BS_LOAD;
			ppp_pkg::BS_LOAD:  state_d = ppp_pkg::BS_DIV;
			ppp_pkg::BS_DIV: begin
				if (last_it) begin
					if (cnt_q != 2'd2) state_d = ppp_pkg::BS_LOAD;
					else if (!vec_q)   state_d = ppp_pkg::BS_SUMSQ;
					else               state_d = ppp_pkg::BS_IDLE;
				end
			end
			default: state_d = ppp_pkg::BS_IDLE;
		endcase
		if (start) state_d = ppp_pkg::BS_CROSS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= 2'd0;
			it_q       <= 5'd0;
			vec_q      <= 1'b0;
			right_q[0] <= -ppp_pkg::Q14_ONE;
			right_q[1] <= 16'sd0;
			right_q[2] <= 16'sd0;
			upn_q[0]   <= 16'sd0;
			upn_q[1]   <= ppp_pkg::Q14_ONE;
			upn_q[2]   <= 16'sd0;
		end else if (start) begin
			cnt_q <= 2'd0;
			vec_q <= 1'b0;
		end else begin
			case (state_q)
				ppp_pkg::BS_CROSS: begin
					vec_q_arr[cnt_q] <= cr;
					cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
					ss_q  <= 36'd0;
				end
				ppp_pkg::BS_SUMSQ: begin
					ss_q <= ss_q + 36'(sq);
					if (cnt_q == 2'd2) begin
						cnt_q <= 2'd0;
						sv_q  <= ss_q + 36'(sq);
						res_q <= 37'd0;
						bit_q <= 37'd1 << 34;
						it_q  <= 5'd17;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ppp_pkg::BS_SQRT: begin
					if (sq_ge) sv_q <= 36'({1'b0, sv_q} - sqt);
					res_q <= res_nx;
					bit_q <= bit_q >> 2;
					it_q  <= it_q - 5'd1;
					if (last_it) n_q <= 19'(res_nx);
				end
				ppp_pkg::BS_LOAD: begin
					rem_q <= (34'(ld_abs) << 15) + 34'(n_q);
					quo_q <= 15'd0;
					it_q  <= 5'd14;
				end
				ppp_pkg::BS_DIV: begin
					if (dv_ge) rem_q <= rem_q - dsh;
					quo_q <= qfin;
					it_q  <= it_q - 5'd1;
					if (last_it) begin
						if (!vec_q) right_q[cnt_q] <= qval;
						else        upn_q[cnt_q]   <= qval;
						if (cnt_q != 2'd2) begin
							cnt_q <= cnt_q + 2'd1;
						end else begin
							cnt_q <= 2'd0;
							vec_q <= 1'b1;
							ss_q  <= 36'd0;
							for (int i = 0; i < 3; i++) vec_q_arr[i] <= 19'(uv[i]);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			basis.right[i] = right_q[i];
			basis.upn[i]   = upn_q[i];
		end
		busy = (state_q != ppp_pkg::BS_IDLE);
	end

endmodule

// ===== rtl/perspective_point_projection_unit.sv =====
// Top level of the perspective point projection unit: configuration registers
// and the projection pipeline. Depends on ppp_pkg and ppp_basis.
//
// Usage: world points enter on the in_valid/in_ready channel, one transaction
// per point (point_x/y/z, Q16.4). Each point yields exactly one output
// transaction on out_valid/out_ready with image_x/y in Q16.4 and the
// depth_clamped and saturated flags. Results leave in input order.
// Throughput is one point per cycle unless the receiver stalls or the basis
// is being rebuilt. Depth of the pipe is set by the 20-stage restoring divider
// that forms x*f/depth and y*f/depth, one quotient bit per stage.
// Configuration is a plain write port (cfg_write_en, cfg_index, cfg_data).
// A write of the forward or up vector starts the basis unit, which rebuilds
// the normalized right and up vectors; in_ready stays low meanwhile. Reset
// loads the default camera and its basis at once, so points are accepted right
// after reset. When the receiver stalls, the whole pipe holds in place and
// in_ready drops; no transaction is lost or repeated.
module perspective_point_projection_unit #(
	parameter int COORD_FRAC_BITS = ppp_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [19:0] point_x,
	input  logic signed [19:0] point_y,
	input  logic signed [19:0] point_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [19:0] image_x,
	output logic signed [19:0] image_y,
	output logic               depth_clamped,
	output logic               saturated
);

	localparam int F   = COORD_FRAC_BITS;
	localparam int DW  = 38;               // dot product width, signed
	localparam int AW  = 37;               // magnitude width
	localparam int QW  = AW + 16;          // magnitude times focal length
	localparam int NW  = QW + F + 2;       // scaled dividend
	localparam int RW  = (NW > 59) ? NW : 59;
	localparam int NDV = 20;               // quotient bits
	localparam int NST = NDV + 7;          // valid stages up to the output
	localparam int ZT  = ((1 << (F + 14)) + 50) / 100;
	localparam logic signed [DW-1:0] Z_THR = DW'(ZT);

	// Configuration registers.
	logic signed [19:0] cam_pos_x_q, cam_pos_y_q, cam_pos_z_q;
	logic [47:0]        cam_forward_q, cam_up_q;
	logic [15:0]        focal_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_pos_x_q    <= ppp_pkg::CAM_POS_X_RST;
			cam_pos_y_q    <= ppp_pkg::CAM_POS_Y_RST;
			cam_pos_z_q    <= ppp_pkg::CAM_POS_Z_RST;
			cam_forward_q  <= ppp_pkg::CAM_FORWARD_RST;
			cam_up_q       <= ppp_pkg::CAM_UP_RST;
			focal_length_q <= ppp_pkg::FOCAL_LENGTH_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				ppp_pkg::REG_CAM_POS_X:    cam_pos_x_q    <= cfg_data[19:0];
				ppp_pkg::REG_CAM_POS_Y:    cam_pos_y_q    <= cfg_data[19:0];
				ppp_pkg::REG_CAM_POS_Z:    cam_pos_z_q    <= cfg_data[19:0];
				ppp_pkg::REG_CAM_FORWARD:  cam_forward_q  <= cfg_data;
				ppp_pkg::REG_CAM_UP:       cam_up_q       <= cfg_data;
				ppp_pkg::REG_FOCAL_LENGTH: focal_length_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The basis only depends on forward and up, so only those writes rebuild it.
	logic            basis_start;
	logic            basis_busy;
	ppp_pkg::basis_t basis;

	assign basis_start = cfg_write_en &&
		(cfg_index == ppp_pkg::REG_CAM_FORWARD || cfg_index == ppp_pkg::REG_CAM_UP);

	ppp_basis u_basis (
		.clk   (clk),
		.arst_n(arst_n),
		.start (basis_start),
		.fwd   (cam_forward_q),
		.up    (cam_up_q),
		.basis (basis),
		.busy  (basis_busy)
	);

	// Global advance: the pipe moves whenever the output slot is free or taken.
	logic en;
	logic accept;
	logic [NST:1] v_s;

	assign en       = !v_s[NST] || out_ready;
	assign in_ready = en && !basis_busy;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NST-1:1], accept};
		end
	end

	// Stage 1: point relative to the camera.
	logic signed [20:0] rel_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			rel_s1[0] <= 21'(point_x) - 21'(cam_pos_x_q);
			rel_s1[1] <= 21'(point_y) - 21'(cam_pos_y_q);
			rel_s1[2] <= 21'(point_z) - 21'(cam_pos_z_q);
		end
	end

	// Stage 2: the nine products of the three dot products.
	logic signed [15:0] rgt [3];
	logic signed [15:0] upv [3];
	logic signed [15:0] fwv [3];
	logic signed [36:0] prx_s2 [3];
	logic signed [36:0] pry_s2 [3];
	logic signed [36:0] prz_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rgt[i] = $signed(basis.right[i]);
			upv[i] = $signed(basis.upn[i]);
			fwv[i] = $signed(cam_forward_q[16*i +: 16]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prx_s2[i] <= rel_s1[i] * rgt[i];
				pry_s2[i] <= rel_s1[i] * upv[i];
				prz_s2[i] <= rel_s1[i] * fwv[i];
			end
		end
	end

	// Stage 3: sums and the depth floor.
	logic signed [DW-1:0] xsum, ysum, zsum;
	logic signed [DW-1:0] x_s3, y_s3, z_s3;
	logic                 clamp_s3;

	always_comb begin
		xsum = DW'(prx_s2[0]) + DW'(prx_s2[1]) + DW'(prx_s2[2]);
		ysum = DW'(pry_s2[0]) + DW'(pry_s2[1]) + DW'(pry_s2[2]);
		zsum = DW'(prz_s2[0]) + DW'(prz_s2[1]) + DW'(prz_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3     <= xsum;
			y_s3     <= ysum;
			clamp_s3 <= zsum < Z_THR;
			z_s3     <= (zsum < Z_THR) ? Z_THR : zsum;
		end
	end

	// Stage 4: sign and magnitude.
	logic [AW-1:0] ax_s4, ay_s4, z_s4;
	logic          negx_s4, negy_s4, clamp_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			negx_s4  <= x_s3[DW-1];
			negy_s4  <= y_s3[DW-1];
			ax_s4    <= x_s3[DW-1] ? AW'(-x_s3) : AW'(x_s3);
			ay_s4    <= y_s3[DW-1] ? AW'(-y_s3) : AW'(y_s3);
			z_s4     <= z_s3[AW-1:0];
			clamp_s4 <= clamp_s3;
		end
	end

	// Stage 5: magnitude times focal length as two partial products.
	logic [34:0]   xlo_s5, ylo_s5;
	logic [33:0]   xhi_s5, yhi_s5;
	logic [AW-1:0] z_s5;
	logic          negx_s5, negy_s5, clamp_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			xlo_s5   <= ax_s4[18:0] * focal_length_q;
			xhi_s5   <= ax_s4[AW-1:19] * focal_length_q;
			ylo_s5   <= ay_s4[18:0] * focal_length_q;
			yhi_s5   <= ay_s4[AW-1:19] * focal_length_q;
			z_s5     <= z_s4;
			negx_s5  <= negx_s4;
			negy_s5  <= negy_s4;
			clamp_s5 <= clamp_s4;
		end
	end

	// Stage 6 is entry 0 of the divider arrays: the rounded quotient is
	// floor((q * 2^(F+1) + z) / (2z)); anything at or above 2^20 saturates.
	logic [QW-1:0] qx, qy;
	logic [RW-1:0] nx, ny, zov;

	always_comb begin
		qx  = (QW'(xhi_s5) << 19) + QW'(xlo_s5);
		qy  = (QW'(yhi_s5) << 19) + QW'(ylo_s5);
		nx  = (RW'(qx) << (F + 1)) + RW'(z_s5);
		ny  = (RW'(qy) << (F + 1)) + RW'(z_s5);
		zov = RW'(z_s5) << (NDV + 1);
	end

	logic [RW-1:0]  xrem_s [NDV+1];
	logic [RW-1:0]  yrem_s [NDV+1];
	logic [NDV-1:0] xquo_s [NDV+1];
	logic [NDV-1:0] yquo_s [NDV+1];
	logic [AW-1:0]  zd_s   [NDV+1];
	logic           negx_s [NDV+1];
	logic           negy_s [NDV+1];
	logic           ovfx_s [NDV+1];
	logic           ovfy_s [NDV+1];
	logic           clamp_s [NDV+1];

	always_ff @(posedge clk) begin
		if (en) begin
			xrem_s[0]  <= nx;
			yrem_s[0]  <= ny;
			xquo_s[0]  <= '0;
			yquo_s[0]  <= '0;
			zd_s[0]    <= z_s5;
			negx_s[0]  <= negx_s5;
			negy_s[0]  <= negy_s5;
			ovfx_s[0]  <= nx >= zov;
			ovfy_s[0]  <= ny >= zov;
			clamp_s[0] <= clamp_s5;
		end
	end

	// Restoring divider, one quotient bit per stage from the top bit down.
	for (genvar k = 0; k < NDV; k++) begin : g_div
		logic [RW-1:0] dsub;
		logic          gex, gey;

		assign dsub = RW'(zd_s[k]) << (NDV - k);
		assign gex  = xrem_s[k] >= dsub;
		assign gey  = yrem_s[k] >= dsub;

		always_ff @(posedge clk) begin
			if (en) begin
				xrem_s[k+1]  <= gex ? xrem_s[k] - dsub : xrem_s[k];
				yrem_s[k+1]  <= gey ? yrem_s[k] - dsub : yrem_s[k];
				xquo_s[k+1]  <= {xquo_s[k][NDV-2:0], gex};
				yquo_s[k+1]  <= {yquo_s[k][NDV-2:0], gey};
				zd_s[k+1]    <= zd_s[k];
				negx_s[k+1]  <= negx_s[k];
				negy_s[k+1]  <= negy_s[k];
				ovfx_s[k+1]  <= ovfx_s[k];
				ovfy_s[k+1]  <= ovfy_s[k];
				clamp_s[k+1] <= clamp_s[k];
			end
		end
	end

	// Output register: limits, sign and flags.
	logic [19:0] mx, my;
	logic        satx, saty;
	logic signed [19:0] image_x_q, image_y_q;
	logic        clamp_q, sat_q;

	always_comb begin
		mx   = xquo_s[NDV];
		my   = yquo_s[NDV];
		satx = ovfx_s[NDV] || (negx_s[NDV] ? (mx > ppp_pkg::IMG_MIN) : (mx > ppp_pkg::IMG_MAX));
		saty = ovfy_s[NDV] || (negy_s[NDV] ? (my > ppp_pkg::IMG_MIN) : (my > ppp_pkg::IMG_MAX));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (negx_s[NDV]) image_x_q <= satx ? ppp_pkg::IMG_MIN : -mx;
			else             image_x_q <= satx ? ppp_pkg::IMG_MAX : mx;
			if (negy_s[NDV]) image_y_q <= saty ? ppp_pkg::IMG_MIN : -my;
			else             image_y_q <= saty ? ppp_pkg::IMG_MAX : my;
			clamp_q <= clamp_s[NDV];
			sat_q   <= satx || saty;
		end
	end

	assign out_valid     = v_s[NST];
	assign image_x       = image_x_q;
	assign image_y       = image_y_q;
	assign depth_clamped = clamp_q;
	assign saturated     = sat_q;

endmodule

// ===== rtl/ppp_checker.sv =====
// Port-level checks for the perspective point projection unit, and the bind
// that attaches them to the top level. Depends on ppp_pkg.
module ppp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_write_en,
	input logic [2:0]  cfg_index,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [19:0] image_x,
	input logic [19:0] image_y,
	input logic        saturated
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(image_x) && $stable(image_y))
		else $error("output transaction changed while stalled");

	// A saturated result shows a limit value on at least one coordinate.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			image_x == ppp_pkg::IMG_MAX || image_x == ppp_pkg::IMG_MIN ||
			image_y == ppp_pkg::IMG_MAX || image_y == ppp_pkg::IMG_MIN)
		else $error("saturated flag without a limit value");

	// A new forward or up vector blocks input while the basis is rebuilt.
	a_basis_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write_en &&
		(cfg_index == ppp_pkg::REG_CAM_FORWARD || cfg_index == ppp_pkg::REG_CAM_UP)
		|=> !in_ready)
		else $error("input accepted during basis rebuild");

endmodule

bind perspective_point_projection_unit ppp_checker u_ppp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_write_en(cfg_write_en),
	.cfg_index   (cfg_index),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.image_x     (image_x),
	.image_y     (image_y),
	.saturated   (saturated)
);
